>>> rtl/core/peer_weighted_round_robin_selector_top_defines.svh
// assertion macros for the peer selector checker
// used by the checker module only
`ifndef PEER_WEIGHTED_ROUND_ROBIN_SELECTOR_TOP_DEFINES_SVH
`define PEER_WEIGHTED_ROUND_ROBIN_SELECTOR_TOP_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define PWRR_ASSERT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pwrr check failed");
// next-cycle implication
`define PWRR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pwrr check failed");
`endif

>>> rtl/core/pwrr_pkg.sv
// package for the peer selector: widths, codes, class pattern
// no dependencies
`timescale 1ns / 1ps
package pwrr_pkg;
    localparam int MaxPeers  = 64;
    localparam int PeerW     = 6;
    localparam int MaxSelect = 16;
    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_FINISH = 2'd1;
    localparam logic [1:0] ACT_SELECT = 2'd2;
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_PRESENT = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;
    localparam logic [1:0] ST_NONE    = 2'd3;
    localparam logic [1:0] REG_FAST   = 2'd0;
    localparam logic [1:0] REG_MEDIUM = 2'd1;
    localparam logic [1:0] REG_PERIOD = 2'd2;
    localparam logic [15:0] Q_ONE = 16'd32768;
    localparam logic [15:0] W_OLD = 16'd58982;
    localparam logic [15:0] W_NEW = 16'd6554;

    typedef struct packed {
        logic [1:0]       action;
        logic [PeerW-1:0] peer_index;
        logic             received;
        logic [63:0]      request_time_ns;
        logic [63:0]      current_time_ns;
        logic [4:0]       select_count;
    } in_word_t;

    typedef struct packed {
        logic [1:0]       status;
        logic             found;
        logic [PeerW-1:0] selected_peer;
        logic             last;
    } out_word_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;       // capture input word
        logic do_add;
        logic fin_start;  // first finish step: capture old averages and the clamped diff
        logic fin_mul;    // multiply step
        logic fin_write;  // write averages
        logic cls_clear;  // clear class counters, pointers and scan
        logic cls_step;   // classify one peer
        logic sel_step;   // walk one pattern slot
        logic emit_pick;
        logic emit_single;
        logic [1:0] single_status;
    } cmd_t;

    typedef struct packed {
        logic       valid_hit;      // captured peer valid
        logic       index_ok;
        logic       cls_done;
        logic       need_reshuffle;
        logic       slot_has_peer;
        logic       all_empty;
        logic       out_busy;
        logic [1:0] action;
        logic [4:0] want;
    } status_t;

    // class of each pattern slot
    function automatic logic [1:0] slot_class(input logic [3:0] pos);
        logic [1:0] c;
        unique case (pos)
            4'd2, 4'd5, 4'd8, 4'd11, 4'd13: c = 2'd1;
            4'd14: c = 2'd2;
            4'd15: c = 2'd3;
            default: c = 2'd0;
        endcase
        return c;
    endfunction
endpackage

>>> rtl/core/pwrr_if.sv
// valid/ready channel carrying one word
// depends on nothing; payload width via type parameter
`timescale 1ns / 1ps
interface pwrr_if #(parameter type word_t = logic) ();
    logic  valid;
    logic  ready;
    word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/peer_weighted_round_robin_selector_top.sv
// One request word is taken at a time. Add, unknown-peer and unknown actions pass
// through capture and decode; a finish through capture, decode, one multiply
// stage and write back. A select takes capture and decode, then walks one pattern
// slot per cycle while the output is not stalled, sees the pick count reached and
// closes; a zero count or an empty table closes without a pick. Up to 16 slots may
// be walked per pick when only a sparse class holds peers. A reshuffle boundary adds
// the class sort: 64 peer reads, each classified in the cycle after its read.
// Result words wait in one output register; a stalled sink holds the walk.
// depends on pwrr_pkg, pwrr_if, pwrr_ctrl, pwrr_dp
`timescale 1ns / 1ps
module peer_weighted_round_robin_selector_top (
    input  logic        clk,
    input  logic        rst_n,
    pwrr_if.sink        in_ch,
    pwrr_if.source      out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pwrr_pkg::*;

    cmd_t    cmd;
    status_t st;
    logic [31:0] fast_reg;
    logic [31:0] medium_reg;
    logic [3:0]  period_reg;
    logic [1:0]  ridx;

    assign pready = 1'b1;
    assign ridx   = paddr[3:2];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_reg   <= 32'd50000000;
            medium_reg <= 32'd100000000;
            period_reg <= 4'd10;
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'b00)
        begin
            unique case (ridx)
                REG_FAST:   fast_reg   <= pwdata;
                REG_MEDIUM: medium_reg <= pwdata;
                REG_PERIOD: period_reg <= pwdata[3:0];
                default:    ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (ridx)
            REG_FAST:   prdata = fast_reg;
            REG_MEDIUM: prdata = medium_reg;
            REG_PERIOD: prdata = {28'd0, period_reg};
            default:    prdata = '0;
        endcase
    end

    pwrr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .st       (st),
        .cmd      (cmd)
    );

    pwrr_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_data      (in_ch.data),
        .cmd          (cmd),
        .st           (st),
        .fast_limit   (fast_reg),
        .medium_limit (medium_reg),
        .period       (period_reg),
        .out_valid    (out_ch.valid),
        .out_ready    (out_ch.ready),
        .out_data     (out_ch.data)
    );
endmodule

>>> rtl/core/pwrr_ctrl.sv
// controller state machine for the peer selector
// depends on pwrr_pkg
`timescale 1ns / 1ps
module pwrr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pwrr_pkg::status_t st,
    output pwrr_pkg::cmd_t    cmd
);
    import pwrr_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_WR   = 3'd3;
    localparam logic [2:0] S_CLS  = 3'd4;
    localparam logic [2:0] S_SEL  = 3'd5;
    localparam logic [2:0] S_FIN2 = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [4:0] got_reg, got_next;

    assign in_ready = (state_reg == S_IDLE) && !st.out_busy;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        got_next   = got_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                if (!st.out_busy)
                begin
                    got_next = '0;
                    priority if (st.action == ACT_ADD)
                    begin
                        cmd.emit_single   = 1'b1;
                        cmd.single_status = !st.index_ok ? ST_UNKNOWN :
                                            st.valid_hit ? ST_PRESENT : ST_OK;
                        cmd.do_add        = st.index_ok && !st.valid_hit;
                        state_next        = S_IDLE;
                    end
                    else if (st.action == ACT_FINISH)
                    begin
                        if (!st.index_ok || !st.valid_hit)
                        begin
                            cmd.emit_single   = 1'b1;
                            cmd.single_status = ST_UNKNOWN;
                            state_next        = S_IDLE;
                        end
                        else
                        begin
                            cmd.fin_start = 1'b1;
                            state_next    = S_MUL;
                        end
                    end
                    else if (st.action == ACT_SELECT)
                    begin
                        if (st.need_reshuffle)
                        begin
                            cmd.cls_clear = 1'b1;
                            state_next    = S_CLS;
                        end
                        else
                        begin
                            state_next = S_SEL;
                        end
                    end
                    else
                    begin
                        cmd.emit_single   = 1'b1;
                        cmd.single_status = ST_OK;
                        state_next        = S_IDLE;
                    end
                end
            end
            S_MUL:
            begin
                cmd.fin_mul = 1'b1;
                state_next  = S_WR;
            end
            S_WR:
            begin
                if (!st.out_busy)
                begin
                    cmd.fin_write     = 1'b1;
                    cmd.emit_single   = 1'b1;
                    cmd.single_status = ST_OK;
                    state_next        = S_IDLE;
                end
            end
            S_CLS:
            begin
                cmd.cls_step = 1'b1;
                if (st.cls_done)
                begin
                    state_next = S_SEL;
                end
            end
            S_SEL:
            begin
                if (got_reg >= st.want)
                begin
                    state_next = S_FIN2;
                end
                else if (!st.out_busy)
                begin
                    cmd.sel_step  = 1'b1;
                    cmd.emit_pick = st.slot_has_peer;
                    if (st.slot_has_peer)
                    begin
                        got_next = got_reg + 5'd1;
                    end
                    if (st.all_empty)
                    begin
                        state_next = S_FIN2;
                    end
                end
            end
            S_FIN2:
            begin
                // zero picks: one closing word; else the last pick already went out
                if (got_reg == '0)
                begin
                    if (!st.out_busy)
                    begin
                        cmd.emit_single   = 1'b1;
                        cmd.single_status = (st.want != '0) ? ST_NONE : ST_OK;
                        state_next        = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            got_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            got_reg   <= got_next;
        end
    end
endmodule

>>> rtl/core/pwrr_dp.sv
// datapath: peer table, averages, class lists, pattern walk, output word
// depends on pwrr_pkg
`timescale 1ns / 1ps
module pwrr_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  pwrr_pkg::in_word_t  in_data,
    input  pwrr_pkg::cmd_t      cmd,
    output pwrr_pkg::status_t   st,
    input  logic [31:0]         fast_limit,
    input  logic [31:0]         medium_limit,
    input  logic [3:0]          period,
    output logic                out_valid,
    input  logic                out_ready,
    output pwrr_pkg::out_word_t out_data
);
    import pwrr_pkg::*;

    in_word_t in_reg;
    logic [MaxPeers-1:0] valid_reg;
    logic [MaxPeers-1:0] sample_reg;
    logic [15:0] hit_mem [MaxPeers];
    logic [31:0] rtt_mem [MaxPeers];
    logic [PeerW-1:0] list_mem [4*MaxPeers];
    logic [PeerW:0]   cnt_reg [4];
    logic [PeerW-1:0] ptr_reg [4];
    logic [3:0] pos_reg;
    logic [3:0] cyc_reg;
    logic [PeerW:0] scan_reg;

    // scan read stage: one peer entry per cycle
    logic [15:0]      rd_hit_reg;
    logic [31:0]      rd_rtt_reg;
    logic             rd_valid_reg;
    logic             rd_sample_reg;
    logic [PeerW-1:0] rd_idx_reg;

    // finish working registers
    logic [15:0] hit_old_reg;
    logic [31:0] rtt_old_reg;
    logic [31:0] sample_reg32;
    logic        first_reg;
    logic [31:0] hit_prod_reg;
    logic [47:0] rtt_prod_reg;

    logic out_valid_reg;
    out_word_t out_reg;
    logic [4:0] want_reg;
    logic [4:0] picked_reg;

    logic [PeerW-1:0] pidx;
    logic [63:0] diff;
    logic [1:0]  sc;
    logic [PeerW-1:0] sp;
    logic [PeerW-1:0] scan_idx;
    logic [1:0] cls;
    logic [PeerW:0] ptr_next;
    logic [4:0] want_cap;
    logic [3:0] pos_next;
    logic [3:0] cyc_inc;
    logic       cls_write;

    assign pidx = in_reg.peer_index;
    assign diff = in_reg.current_time_ns - in_reg.request_time_ns;
    assign sc   = slot_class(pos_reg);
    assign sp   = (ptr_reg[sc] >= cnt_reg[sc][PeerW-1:0] && cnt_reg[sc][PeerW] == 1'b0)
                  ? '0 : ptr_reg[sc];
    assign ptr_next = {1'b0, sp} + 1'b1;
    assign scan_idx = scan_reg[PeerW-1:0];
    assign want_cap = (in_data.select_count > 5'(MaxSelect)) ? 5'(MaxSelect)
                      : in_data.select_count;
    assign pos_next = pos_reg + 4'd1;
    assign cyc_inc  = cyc_reg + 4'd1;
    // classify stage runs in the cycle after the read stage
    assign cls_write = cmd.cls_step && scan_reg != '0 && rd_valid_reg;

    // class of the peer read in the previous scan cycle
    always_comb
    begin
        priority if (rd_sample_reg && rd_hit_reg == '0)
            cls = 2'd3;
        else if (rd_rtt_reg < fast_limit)
            cls = 2'd0;
        else if (rd_rtt_reg < medium_limit)
            cls = 2'd1;
        else
            cls = 2'd2;
    end

    assign st.valid_hit      = valid_reg[pidx];
    assign st.index_ok       = 1'b1;
    assign st.cls_done       = scan_reg == 7'(MaxPeers);
    assign st.need_reshuffle = pos_reg == '0 && cyc_reg == '0;
    assign st.slot_has_peer  = cnt_reg[sc] != '0;
    assign st.all_empty      = cnt_reg[0] == '0 && cnt_reg[1] == '0
                               && cnt_reg[2] == '0 && cnt_reg[3] == '0;
    assign st.out_busy       = out_valid_reg && !out_ready;
    assign st.action         = in_reg.action;
    assign st.want           = want_reg;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // captured input, scan reads and finish arithmetic
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_reg   <= in_data;
            want_reg <= want_cap;
        end
        if (cmd.cls_step && !scan_reg[PeerW])
        begin
            rd_hit_reg    <= hit_mem[scan_idx];
            rd_rtt_reg    <= rtt_mem[scan_idx];
            rd_valid_reg  <= valid_reg[scan_idx];
            rd_sample_reg <= sample_reg[scan_idx];
            rd_idx_reg    <= scan_idx;
        end
        if (cmd.fin_start)
        begin
            hit_old_reg  <= hit_mem[pidx];
            rtt_old_reg  <= rtt_mem[pidx];
            first_reg    <= !sample_reg[pidx];
            sample_reg32 <= (diff[63:32] != '0) ? 32'hFFFF_FFFF : diff[31:0];
        end
        if (cmd.fin_mul)
        begin
            hit_prod_reg <= 32'(hit_old_reg) * 32'(W_OLD) + 32'(Q_ONE) * 32'(W_NEW);
            rtt_prod_reg <= 48'(rtt_old_reg) * 48'(W_OLD) + 48'(sample_reg32) * 48'(W_NEW);
        end
    end

    // table memories
    always_ff @(posedge clk)
    begin
        if (cmd.do_add)
        begin
            hit_mem[pidx] <= '0;
            rtt_mem[pidx] <= '0;
        end
        if (cmd.fin_write)
        begin
            if (first_reg)
                hit_mem[pidx] <= in_reg.received ? Q_ONE : '0;
            else if (in_reg.received)
                hit_mem[pidx] <= hit_prod_reg[31:16];
            if (in_reg.received)
                rtt_mem[pidx] <= (rtt_old_reg == '0) ? sample_reg32 : rtt_prod_reg[47:16];
        end
        if (cls_write)
            list_mem[{cls, cnt_reg[cls][PeerW-1:0]}] <= rd_idx_reg;
    end

    // control state of the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            sample_reg    <= '0;
            for (int c = 0; c < 4; c++)
            begin
                cnt_reg[c] <= '0;
                ptr_reg[c] <= '0;
            end
            pos_reg       <= '0;
            cyc_reg       <= '0;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            picked_reg    <= '0;
        end
        else
        begin
            if (cmd.emit_pick || cmd.emit_single)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (cmd.load)
                picked_reg <= '0;
            if (cmd.do_add)
            begin
                valid_reg[pidx]  <= 1'b1;
                sample_reg[pidx] <= 1'b0;
                pos_reg          <= '0;
                cyc_reg          <= '0;
            end
            if (cmd.fin_write)
                sample_reg[pidx] <= 1'b1;
            if (cmd.cls_clear)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    cnt_reg[c] <= '0;
                    ptr_reg[c] <= '0;
                end
                scan_reg <= '0;
            end
            if (cmd.cls_step)
            begin
                if (cls_write)
                    cnt_reg[cls] <= cnt_reg[cls] + 1'b1;
                scan_reg <= scan_reg + 1'b1;
            end
            if (cmd.sel_step)
            begin
                if (st.slot_has_peer)
                    ptr_reg[sc] <= (ptr_next >= cnt_reg[sc]) ? '0 : ptr_next[PeerW-1:0];
                pos_reg <= pos_next;
                if (pos_next == '0)
                    cyc_reg <= (cyc_inc >= period) ? '0 : cyc_inc;
            end
            if (cmd.emit_pick)
            begin
                out_reg.status       <= ST_OK;
                out_reg.found        <= 1'b1;
                out_reg.selected_peer <= list_mem[{sc, sp}];
                out_reg.last         <= (picked_reg + 5'd1 == want_reg) || st.all_empty;
                picked_reg           <= picked_reg + 5'd1;
            end
            if (cmd.emit_single)
            begin
                out_reg       <= '{status: cmd.single_status, found: 1'b0,
                                   selected_peer: '0, last: 1'b1};
            end
        end
    end
endmodule

>>> rtl/core/pwrr_checker.sv
// port-level checker for the peer selector, bound to the top level
// depends on pwrr_pkg and the defines header
`timescale 1ns / 1ps
`include "peer_weighted_round_robin_selector_top_defines.svh"
module pwrr_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input pwrr_pkg::out_word_t out_data
);
    import pwrr_pkg::*;

    // held result word stays put
    `PWRR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, $stable(out_data) && out_valid)
    // a found pick always reports ok status
    `PWRR_ASSERT(a_found_ok, out_valid && out_data.found, out_data.status == ST_OK)
    // a word without a pick closes its request
    `PWRR_ASSERT(a_nofind_last, out_valid && !out_data.found, out_data.last)
    // no new request taken in the cycle right after one
    `PWRR_ASSERT_NEXT(a_one_at_time, in_valid && in_ready, !in_ready)
endmodule

bind peer_weighted_round_robin_selector_top pwrr_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
);
